>>> hdl/puct_pkg.sv
package puct_pkg;

  localparam int MOVE_W    = 14;
  localparam int PRIOR_W   = 16;
  localparam int VALUE_W   = 16;
  localparam int GAIN_W    = 16;
  localparam int NODE_W    = 32;
  localparam int ROOT_W    = 32;
  localparam int CP_W      = 32;
  localparam int WIDE_W    = 64;
  localparam int Q_W       = 32;
  localparam int Q_SHIFT   = 16;
  localparam int E_SHIFT   = 13;
  localparam int E_W       = WIDE_W - E_SHIFT;
  localparam int SCORE_W   = E_W + 2;
  localparam int OUT_CNT_W = 24;
  localparam int STATUS_W  = 2;
  localparam int DIV_CNT_W = 7;

  localparam logic [GAIN_W-1:0]    GAIN_RESET = 16'd4096;
  localparam logic [NODE_W-1:0]    NODE_ONE   = 32'd1;
  localparam logic [NODE_W-1:0]    NODE_MAX   = 32'hFFFF_FFFF;
  localparam logic [DIV_CNT_W-1:0] Q_ITERS    = 7'd32;
  localparam logic [DIV_CNT_W-1:0] E_ITERS    = 7'd64;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;

  typedef enum logic [2:0] {
    CMD_CLEAR    = 3'd0,
    CMD_LOAD     = 3'd1,
    CMD_START    = 3'd2,
    CMD_COMPLETE = 3'd3,
    CMD_SELECT   = 3'd4,
    CMD_QUERY    = 3'd5
  } cmd_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CLR,
    S_UPD,
    S_SQRT,
    S_SEL_RD,
    S_SEL_CHK,
    S_SEL_MUL,
    S_SEL_DIVQ,
    S_SEL_EST,
    S_SEL_DIVE,
    S_SEL_CMP
  } state_t;

endpackage

>>> hdl/puct_branch_stats_select_core.sv
// Branch table of one search node with PUCT move selection.
// Command channel: start with in_command, in_move_code, in_prior_in and
// in_visit_value is taken at a rising edge where busy is low. Each command
// gives exactly one result: out_valid is high for one cycle with
// out_chosen_move, out_count_out and out_status; the receiver takes it then
// and cannot stall it. cfg_wr_en writes cfg_wr_data into the exploration
// gain; write it only while the block is idle.
// Load, start visit, complete visit, query and unused codes go through the
// update state to their result. Clear sweeps the table memory, one entry a
// cycle. Select runs a 32-step square root, then scans every entry: an
// absent entry passes only the read and check states, a present one also
// uses the shared restoring divider that makes one quotient bit per cycle
// (32 bits for the mean, skipped with no completed visit, and 64 for the
// exploration term). A new command can be taken at the edge that ends the
// result strobe cycle.
// Reset: the gain returns to 4096 and the node total to one, and the block
// stays busy while it clears the table memory.
module puct_branch_stats_select_core
  import puct_pkg::*;
#(
  parameter int TABLE_ENTRIES = 16384,
  parameter int COUNT_BITS    = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [2:0]           in_command,
  input  logic [MOVE_W-1:0]    in_move_code,
  input  logic [PRIOR_W-1:0]   in_prior_in,
  input  logic signed [VALUE_W-1:0] in_visit_value,
  output logic                 out_valid,
  output logic [MOVE_W-1:0]    out_chosen_move,
  output logic [OUT_CNT_W-1:0] out_count_out,
  output logic [STATUS_W-1:0]  out_status,
  input  logic                 cfg_wr_en,
  input  logic [GAIN_W-1:0]    cfg_wr_data
);

  localparam int AW    = $clog2(TABLE_ENTRIES);
  localparam int SUM_W = COUNT_BITS + 16;
  localparam int DVW   = COUNT_BITS + 1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_ENTRIES - 1);

  typedef struct packed {
    logic                  present;
    logic [PRIOR_W-1:0]    prior;
    logic [COUNT_BITS-1:0] started;
    logic [COUNT_BITS-1:0] done_cnt;
    logic [SUM_W-1:0]      sum;
  } entry_t;

  localparam int EW = $bits(entry_t);

  state_t state_r, state_nxt;

  cmd_t                      cmd_r, cmd_nxt;
  logic [AW-1:0]             mv_r, mv_nxt;
  logic                      ok_r, ok_nxt;
  logic [PRIOR_W-1:0]        prior_r, prior_nxt;
  logic signed [VALUE_W-1:0] value_r, value_nxt;
  logic [GAIN_W-1:0]         gain_r, gain_nxt;
  logic [NODE_W-1:0]         node_r, node_nxt;
  logic [AW-1:0]             scan_r, scan_nxt;
  logic [ROOT_W-1:0]         root_r, root_nxt;
  logic                      found_r, found_nxt;
  logic signed [SCORE_W-1:0] best_r, best_nxt;
  logic [AW-1:0]             best_mv_r, best_mv_nxt;
  logic                      q_neg_r, q_neg_nxt;
  logic [WIDE_W-1:0]         dvd_r, dvd_nxt;
  logic [COUNT_BITS-1:0]     done_cnt_r, done_cnt_nxt;
  logic [COUNT_BITS-1:0]     started_r, started_nxt;
  logic [CP_W-1:0]           cp_r, cp_nxt;
  logic [WIDE_W-1:0]         x_r, x_nxt;
  logic signed [Q_W-1:0]     q_r, q_nxt;
  logic [E_W-1:0]            e_r, e_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic [MOVE_W-1:0]         out_move_r, out_move_nxt;
  logic [OUT_CNT_W-1:0]      out_count_r, out_count_nxt;
  logic [STATUS_W-1:0]       out_status_r, out_status_nxt;

  logic                      ram_we;
  logic [AW-1:0]             ram_waddr, ram_raddr;
  entry_t                    ram_wdata, ent;
  logic [EW-1:0]             ram_rdata;

  logic                      div_start, div_done;
  logic [DVW-1:0]            div_rem_init, div_divisor;
  logic [WIDE_W-1:0]         div_dividend, div_quo;
  logic [DIV_CNT_W-1:0]      div_iters;

  logic                      sq_start, sq_done;
  logic [ROOT_W-1:0]         sq_root;

  logic                      scan_last, here;
  logic [SUM_W-1:0]          mag;
  logic [Q_W-1:0]            qm;
  logic signed [SCORE_W-1:0] score;
  logic                      take;

  puct_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  puct_div #(.DVW(DVW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .rem_init (div_rem_init),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .iters    (div_iters),
    .done     (div_done),
    .quotient (div_quo)
  );

  puct_isqrt u_isqrt (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (sq_start),
    .radicand_hi (node_r),
    .done        (sq_done),
    .root        (sq_root)
  );

  assign ent       = entry_t'(ram_rdata);
  assign scan_last = scan_r == LAST_ADDR;
  assign here      = ok_r && ent.present;
  assign mag       = ent.sum[SUM_W-1] ? SUM_W'(~ent.sum + SUM_W'(1)) : ent.sum;
  assign qm        = div_quo[Q_W-1:0];
  assign score     = {{(SCORE_W-Q_W){q_r[Q_W-1]}}, q_r} + $signed({2'b00, e_r});
  assign take      = !found_r || (score > best_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT: begin
        if (scan_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          case (cmd_t'(in_command))
            CMD_CLEAR:  state_nxt = S_CLR;
            CMD_SELECT: state_nxt = S_SQRT;
            default:    state_nxt = S_UPD;
          endcase
        end
      end
      S_CLR: begin
        if (scan_last) state_nxt = S_IDLE;
      end
      S_UPD: state_nxt = S_IDLE;
      S_SQRT: begin
        if (sq_done) state_nxt = S_SEL_RD;
      end
      S_SEL_RD: state_nxt = S_SEL_CHK;
      S_SEL_CHK: begin
        if (ent.present) state_nxt = S_SEL_MUL;
        else if (scan_last) state_nxt = S_IDLE;
        else state_nxt = S_SEL_RD;
      end
      S_SEL_MUL: begin
        state_nxt = (done_cnt_r != '0) ? S_SEL_DIVQ : S_SEL_EST;
      end
      S_SEL_DIVQ: begin
        if (div_done) state_nxt = S_SEL_EST;
      end
      S_SEL_EST: state_nxt = S_SEL_DIVE;
      S_SEL_DIVE: begin
        if (div_done) state_nxt = S_SEL_CMP;
      end
      S_SEL_CMP: begin
        state_nxt = scan_last ? S_IDLE : S_SEL_RD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_nxt        = cmd_r;
    mv_nxt         = mv_r;
    ok_nxt         = ok_r;
    prior_nxt      = prior_r;
    value_nxt      = value_r;
    gain_nxt       = cfg_wr_en ? cfg_wr_data : gain_r;
    node_nxt       = node_r;
    scan_nxt       = scan_r;
    root_nxt       = root_r;
    found_nxt      = found_r;
    best_nxt       = best_r;
    best_mv_nxt    = best_mv_r;
    q_neg_nxt      = q_neg_r;
    dvd_nxt        = dvd_r;
    done_cnt_nxt   = done_cnt_r;
    started_nxt    = started_r;
    cp_nxt         = cp_r;
    x_nxt          = x_r;
    q_nxt          = q_r;
    e_nxt          = e_r;
    out_valid_nxt  = 1'b0;
    out_move_nxt   = out_move_r;
    out_count_nxt  = out_count_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_waddr      = mv_r;
    ram_wdata      = ent;
    ram_raddr      = scan_r;
    div_start      = 1'b0;
    div_rem_init   = '0;
    div_dividend   = x_r;
    div_divisor    = DVW'(started_r) + DVW'(1);
    div_iters      = E_ITERS;
    sq_start       = 1'b0;

    case (state_r)
      S_INIT, S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = scan_r;
        ram_wdata = '0;
        scan_nxt  = scan_last ? '0 : scan_r + AW'(1);
        if (state_r == S_CLR && scan_last) begin
          node_nxt       = NODE_ONE;
          out_valid_nxt  = 1'b1;
          out_move_nxt   = '0;
          out_count_nxt  = '0;
          out_status_nxt = ST_OK;
        end
      end
      S_IDLE: begin
        ram_raddr = AW'(in_move_code);
        if (start) begin
          cmd_nxt   = cmd_t'(in_command);
          mv_nxt    = AW'(in_move_code);
          ok_nxt    = 32'(in_move_code) < 32'(TABLE_ENTRIES);
          prior_nxt = in_prior_in;
          value_nxt = in_visit_value;
          scan_nxt  = '0;
          found_nxt = 1'b0;
          sq_start  = cmd_t'(in_command) == CMD_SELECT;
        end
      end
      S_UPD: begin
        out_valid_nxt  = 1'b1;
        out_move_nxt   = '0;
        out_count_nxt  = '0;
        out_status_nxt = ST_OK;
        case (cmd_r)
          CMD_LOAD: begin
            if (!ok_r) begin
              out_status_nxt = ST_ABSENT;
            end else begin
              ram_we    = 1'b1;
              ram_wdata = '{present: 1'b1, prior: prior_r, started: '0,
                            done_cnt: '0, sum: '0};
            end
          end
          CMD_START: begin
            if (!here) begin
              out_status_nxt = ST_ABSENT;
            end else begin
              ram_we = 1'b1;
              if (ent.started != CNT_MAX) ram_wdata.started = ent.started + COUNT_BITS'(1);
              if (node_r != NODE_MAX) node_nxt = node_r + NODE_ONE;
            end
          end
          CMD_COMPLETE: begin
            if (!here) begin
              out_status_nxt = ST_ABSENT;
            end else if (ent.done_cnt != CNT_MAX) begin
              ram_we             = 1'b1;
              ram_wdata.done_cnt = ent.done_cnt + COUNT_BITS'(1);
              ram_wdata.sum      = ent.sum + {{(SUM_W-VALUE_W){value_r[VALUE_W-1]}}, value_r};
            end
          end
          CMD_QUERY: begin
            if (!here) out_status_nxt = ST_ABSENT;
            else out_count_nxt = OUT_CNT_W'(ent.started);
          end
          default: begin
            out_status_nxt = ST_OK;
          end
        endcase
      end
      S_SQRT: begin
        if (sq_done) root_nxt = sq_root;
      end
      S_SEL_CHK: begin
        cp_nxt       = CP_W'(gain_r) * CP_W'(ent.prior);
        started_nxt  = ent.started;
        done_cnt_nxt = ent.done_cnt;
        q_neg_nxt    = ent.sum[SUM_W-1];
        dvd_nxt      = WIDE_W'(mag) << Q_SHIFT;
        if (!ent.present) begin
          if (scan_last) begin
            out_valid_nxt  = 1'b1;
            out_move_nxt   = found_r ? MOVE_W'(best_mv_r) : '0;
            out_count_nxt  = '0;
            out_status_nxt = found_r ? ST_OK : ST_EMPTY;
          end else begin
            scan_nxt = scan_r + AW'(1);
          end
        end
      end
      S_SEL_MUL: begin
        x_nxt = WIDE_W'(cp_r) * WIDE_W'(root_r);
        if (done_cnt_r != '0) begin
          div_start    = 1'b1;
          div_rem_init = DVW'(dvd_r[WIDE_W-1:Q_W]);
          div_dividend = {dvd_r[Q_W-1:0], {(WIDE_W-Q_W){1'b0}}};
          div_divisor  = DVW'(done_cnt_r);
          div_iters    = Q_ITERS;
        end else begin
          q_nxt = '0;
        end
      end
      S_SEL_DIVQ: begin
        if (div_done) q_nxt = q_neg_r ? $signed(~qm + Q_W'(1)) : $signed(qm);
      end
      S_SEL_EST: begin
        div_start = 1'b1;
      end
      S_SEL_DIVE: begin
        if (div_done) e_nxt = div_quo[WIDE_W-1:E_SHIFT];
      end
      S_SEL_CMP: begin
        found_nxt = 1'b1;
        if (take) begin
          best_nxt    = score;
          best_mv_nxt = scan_r;
        end
        if (scan_last) begin
          out_valid_nxt  = 1'b1;
          out_move_nxt   = take ? MOVE_W'(scan_r) : MOVE_W'(best_mv_r);
          out_count_nxt  = '0;
          out_status_nxt = ST_OK;
        end else begin
          scan_nxt = scan_r + AW'(1);
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      gain_r      <= GAIN_RESET;
      node_r      <= NODE_ONE;
      scan_r      <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gain_r      <= gain_nxt;
      node_r      <= node_nxt;
      scan_r      <= scan_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    mv_r         <= mv_nxt;
    ok_r         <= ok_nxt;
    prior_r      <= prior_nxt;
    value_r      <= value_nxt;
    root_r       <= root_nxt;
    best_r       <= best_nxt;
    best_mv_r    <= best_mv_nxt;
    q_neg_r      <= q_neg_nxt;
    dvd_r        <= dvd_nxt;
    done_cnt_r   <= done_cnt_nxt;
    started_r    <= started_nxt;
    cp_r         <= cp_nxt;
    x_r          <= x_nxt;
    q_r          <= q_nxt;
    e_r          <= e_nxt;
    out_move_r   <= out_move_nxt;
    out_count_r  <= out_count_nxt;
    out_status_r <= out_status_nxt;
  end

  assign busy            = state_r != S_IDLE;
  assign out_valid       = out_valid_r;
  assign out_chosen_move = out_move_r;
  assign out_count_out   = out_count_r;
  assign out_status      = out_status_r;

`ifndef NO_ASSERTIONS
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r) else $error("result strobe longer than one cycle");
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_IDLE) else $error("result while still working");
  a_empty_move: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == ST_EMPTY |-> out_move_r == '0)
    else $error("empty select with a move");
  a_node_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    node_r != '0) else $error("node visit total is zero");
`endif

endmodule

>>> hdl/puct_ram.sv
module puct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/puct_div.sv
module puct_div
  import puct_pkg::*;
#(
  parameter int DVW = 25
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DVW-1:0]       rem_init,
  input  logic [WIDE_W-1:0]    dividend,
  input  logic [DVW-1:0]       divisor,
  input  logic [DIV_CNT_W-1:0] iters,
  output logic                 done,
  output logic [WIDE_W-1:0]    quotient
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] left_r, left_nxt;
  logic [DVW-1:0]       rem_r, rem_nxt;
  logic [WIDE_W-1:0]    sh_r, sh_nxt;
  logic [DVW-1:0]       divisor_r, divisor_nxt;
  logic [DVW:0]         trial;
  logic                 ge;

  always_comb begin
    trial       = {rem_r, sh_r[WIDE_W-1]};
    ge          = trial >= {1'b0, divisor_r};
    busy_nxt    = busy_r;
    done_nxt    = 1'b0;
    left_nxt    = left_r;
    rem_nxt     = rem_r;
    sh_nxt      = sh_r;
    divisor_nxt = divisor_r;
    if (start) begin
      busy_nxt    = 1'b1;
      left_nxt    = iters;
      rem_nxt     = rem_init;
      sh_nxt      = dividend;
      divisor_nxt = divisor;
    end else if (busy_r) begin
      rem_nxt  = ge ? DVW'(trial - {1'b0, divisor_r}) : DVW'(trial);
      sh_nxt   = {sh_r[WIDE_W-2:0], ge};
      left_nxt = left_r - DIV_CNT_W'(1);
      if (left_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    left_r    <= left_nxt;
    rem_r     <= rem_nxt;
    sh_r      <= sh_nxt;
    divisor_r <= divisor_nxt;
  end

  assign done     = done_r;
  assign quotient = sh_r;

`ifndef NO_ASSERTIONS
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider restarted while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("divider done without work");
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> rem_r < divisor_r) else $error("partial remainder out of range");
`endif

endmodule

>>> hdl/puct_isqrt.sv
module puct_isqrt
  import puct_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [NODE_W-1:0] radicand_hi,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [4:0]            cnt_r, cnt_nxt;
  logic [WIDE_W-1:0]     rad_r, rad_nxt;
  logic [ROOT_W+1:0]     rem_r, rem_nxt;
  logic [ROOT_W-1:0]     root_r, root_nxt;
  logic [ROOT_W+3:0]     rem_s;
  logic [ROOT_W+1:0]     trial;

  always_comb begin
    rem_s    = {rem_r, rad_r[WIDE_W-1 -: 2]};
    trial    = {root_r, 2'b01};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rad_nxt  = {radicand_hi, {(WIDE_W-NODE_W){1'b0}}};
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      rad_nxt = {rad_r[WIDE_W-3:0], 2'b00};
      cnt_nxt = cnt_r + 5'd1;
      if (rem_s >= (ROOT_W+4)'(trial)) begin
        rem_nxt  = (ROOT_W+2)'(rem_s - (ROOT_W+4)'(trial));
        root_nxt = {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = (ROOT_W+2)'(rem_s);
        root_nxt = {root_r[ROOT_W-2:0], 1'b0};
      end
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

>>> dv/puct_branch_stats_select_core_test.sv
module puct_branch_stats_select_core_test
  import puct_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          ENTRIES       = 16384;
  localparam int unsigned CNT_MAX       = (1 << 24) - 1;
  localparam logic [2:0]  CMD_UNUSED_LO = 3'd6;
  localparam logic [2:0]  CMD_UNUSED_HI = 3'd7;
  localparam int          STALL_LIMIT   = 200000;
  localparam int          REPORT_LIMIT  = 10;
  localparam int          PHASES        = 5;
  localparam int          PHASE_ITEMS   = 53;
  localparam int          POOL_SIZE     = 24;

  typedef struct packed {
    logic [MOVE_W-1:0]    chosen_move;
    logic [OUT_CNT_W-1:0] count_out;
    logic [STATUS_W-1:0]  status;
  } branch_result_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        start = 1'b0;
  logic                        busy;
  logic [2:0]                  in_command = 3'd0;
  logic [MOVE_W-1:0]           in_move_code = '0;
  logic [PRIOR_W-1:0]          in_prior_in = '0;
  logic signed [VALUE_W-1:0]   in_visit_value = '0;
  logic                        out_valid;
  logic [MOVE_W-1:0]           out_chosen_move;
  logic [OUT_CNT_W-1:0]        out_count_out;
  logic [STATUS_W-1:0]         out_status;
  logic                        cfg_wr_en = 1'b0;
  logic [GAIN_W-1:0]           cfg_wr_data = '0;

  // branch table mirror, only entries that are present
  logic [PRIOR_W-1:0] prior_tab [int];
  int unsigned        started_tab [int];
  int unsigned        done_tab [int];
  longint             sum_tab [int];
  logic [NODE_W-1:0]  node_total = NODE_ONE;
  logic [GAIN_W-1:0]  gain_now = GAIN_RESET;

  branch_result_t pending_results [$];
  int             move_pool [POOL_SIZE];
  int             mismatch_count = 0;
  int             stall_cycles = 0;
  bit             gaps_on = 1'b1;

  puct_branch_stats_select_core u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_move_code   (in_move_code),
    .in_prior_in    (in_prior_in),
    .in_visit_value (in_visit_value),
    .out_valid      (out_valid),
    .out_chosen_move(out_chosen_move),
    .out_count_out  (out_count_out),
    .out_status     (out_status),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint unsigned root_of(longint unsigned x);
    longint unsigned r = 0;
    longint unsigned b = 64'h4000_0000_0000_0000;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint branch_score(int m, longint unsigned root);
    longint          q = 0;
    longint unsigned mag;
    longint unsigned cp;
    longint unsigned e;
    if (done_tab[m] != 0) begin
      if (sum_tab[m] < 0) begin
        mag = -sum_tab[m];
        q = -longint'((mag << Q_SHIFT) / 64'(done_tab[m]));
      end else begin
        mag = sum_tab[m];
        q = longint'((mag << Q_SHIFT) / 64'(done_tab[m]));
      end
    end
    cp = 64'(gain_now) * 64'(prior_tab[m]);
    e = (cp * root) / (64'(started_tab[m]) + 64'd1);
    e = e >> E_SHIFT;
    return q + longint'(e);
  endfunction

  function automatic branch_result_t apply_command(logic [2:0] cmd, int m,
      logic [PRIOR_W-1:0] prior, logic signed [VALUE_W-1:0] value);
    branch_result_t  res = '0;
    bit              here;
    bit              found = 1'b0;
    longint          best = 0;
    longint          s;
    longint unsigned root;
    here = prior_tab.exists(m);
    res.status = ST_OK;
    case (cmd)
      CMD_CLEAR: begin
        prior_tab.delete();
        started_tab.delete();
        done_tab.delete();
        sum_tab.delete();
        node_total = NODE_ONE;
      end
      CMD_LOAD: begin
        if (m >= ENTRIES) begin
          res.status = ST_ABSENT;
        end else begin
          prior_tab[m] = prior;
          started_tab[m] = 0;
          done_tab[m] = 0;
          sum_tab[m] = 0;
        end
      end
      CMD_START: begin
        if (!here) begin
          res.status = ST_ABSENT;
        end else begin
          if (started_tab[m] < CNT_MAX) started_tab[m] = started_tab[m] + 1;
          if (node_total != NODE_MAX) node_total = node_total + 1;
        end
      end
      CMD_COMPLETE: begin
        if (!here) begin
          res.status = ST_ABSENT;
        end else if (done_tab[m] < CNT_MAX) begin
          done_tab[m] = done_tab[m] + 1;
          sum_tab[m] = sum_tab[m] + longint'(value);
        end
      end
      CMD_SELECT: begin
        root = root_of({node_total, 32'd0});
        foreach (prior_tab[k]) begin
          s = branch_score(k, root);
          if (!found || s > best) begin
            found = 1'b1;
            best = s;
            res.chosen_move = MOVE_W'(k);
          end
        end
        if (!found) begin
          res.chosen_move = '0;
          res.status = ST_EMPTY;
        end
      end
      CMD_QUERY: begin
        if (!here) res.status = ST_ABSENT;
        else res.count_out = OUT_CNT_W'(started_tab[m]);
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  task automatic check_result();
    branch_result_t want;
    if (pending_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("%0t: result with nothing pending: move %0d count %0d status %0d",
                 $realtime, out_chosen_move, out_count_out, out_status);
      return;
    end
    want = pending_results.pop_front();
    if (out_chosen_move !== want.chosen_move || out_count_out !== want.count_out ||
        out_status !== want.status) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("%0t: move exp %0d got %0d, count exp %0d got %0d, status exp %0d got %0d",
                 $realtime, want.chosen_move, out_chosen_move, want.count_out,
                 out_count_out, want.status, out_status);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      stall_cycles <= 0;
    end else begin
      if ((start && !busy) || out_valid) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (out_valid) check_result();
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("puct_branch_stats_select_core_test: done, errors");
    $finish;
  end

  function automatic int gap_length();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [PRIOR_W-1:0] rand_prior();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return PRIOR_W'($urandom);
  endfunction

  function automatic logic [VALUE_W-1:0] rand_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h8000;
    if (r == 1) return 16'h7FFF;
    return VALUE_W'($urandom);
  endfunction

  // drive one command and hold it until the block takes the transfer
  task automatic send(logic [2:0] cmd, int m, logic [PRIOR_W-1:0] prior,
                      logic [VALUE_W-1:0] value);
    int n;
    @(negedge clk);
    start <= 1'b1;
    in_command <= cmd;
    in_move_code <= MOVE_W'(m);
    in_prior_in <= prior;
    in_visit_value <= value;
    do @(posedge clk); while (busy);
    pending_results.insert(pending_results.size(), apply_command(cmd, m, prior, value));
    n = gap_length();
    if (n > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_gain(logic [GAIN_W-1:0] val);
    drain();
    while (busy) @(posedge clk);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= GAIN_W'($urandom);
    gain_now = val;
  endtask

  task automatic test_empty_table();
    send(CMD_SELECT, $urandom_range(0, ENTRIES - 1), rand_prior(), rand_value());
    send(CMD_QUERY, 5, rand_prior(), rand_value());
    send(CMD_START, 77, rand_prior(), rand_value());
    send(CMD_COMPLETE, 77, rand_prior(), 16'h7FFF);
    send(CMD_UNUSED_LO, 16383, 16'hFFFF, 16'hFFFF);
    send(CMD_UNUSED_HI, 0, 16'h0000, 16'h0000);
  endtask

  task automatic test_load_query();
    send(CMD_LOAD, 0, 16'hFFFF, rand_value());
    send(CMD_LOAD, 16383, 16'h0000, rand_value());
    send(CMD_QUERY, 0, rand_prior(), rand_value());
    send(CMD_QUERY, 16383, rand_prior(), rand_value());
  endtask

  task automatic test_visit_updates();
    send(CMD_START, 0, rand_prior(), rand_value());
    send(CMD_COMPLETE, 0, rand_prior(), 16'h7FFF);
    send(CMD_COMPLETE, 0, rand_prior(), 16'h8000);
    send(CMD_START, 16383, rand_prior(), rand_value());
    send(CMD_COMPLETE, 16383, rand_prior(), 16'h8000);
    send(CMD_QUERY, 0, rand_prior(), rand_value());
    // reload of a present entry wipes its counts
    send(CMD_LOAD, 0, 16'd12345, rand_value());
    send(CMD_QUERY, 0, rand_prior(), rand_value());
  endtask

  task automatic test_select_ties();
    send(CMD_LOAD, 5, 16'd12345, rand_value());
    send(CMD_SELECT, $urandom_range(0, ENTRIES - 1), rand_prior(), rand_value());
  endtask

  task automatic test_gain_extremes();
    set_gain('0);
    send(CMD_SELECT, 0, rand_prior(), rand_value());
    set_gain('1);
    send(CMD_SELECT, 16383, rand_prior(), rand_value());
  endtask

  task automatic test_clear();
    send(CMD_CLEAR, $urandom_range(0, ENTRIES - 1), rand_prior(), rand_value());
    send(CMD_SELECT, 0, rand_prior(), rand_value());
    send(CMD_QUERY, 0, rand_prior(), rand_value());
    set_gain(GAIN_RESET);
  endtask

  task automatic random_item();
    int         r;
    int         m;
    logic [2:0] cmd;
    r = $urandom_range(0, 999);
    m = move_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (r < 200) cmd = CMD_LOAD;
    else if (r < 480) cmd = CMD_START;
    else if (r < 760) cmd = CMD_COMPLETE;
    else if (r < 860) cmd = CMD_QUERY;
    else if (r < 930) begin
      // stray code, most likely absent
      m = $urandom_range(0, ENTRIES - 1);
      case ($urandom_range(0, 2))
        0: cmd = CMD_START;
        1: cmd = CMD_COMPLETE;
        default: cmd = CMD_QUERY;
      endcase
    end
    else if (r < 970) cmd = CMD_SELECT;
    else if (r < 984) cmd = CMD_CLEAR;
    else if (r < 992) cmd = CMD_UNUSED_LO;
    else cmd = CMD_UNUSED_HI;
    send(cmd, m, rand_prior(), rand_value());
  endtask

  task automatic test_random();
    logic [GAIN_W-1:0] gains [PHASES];
    move_pool[0] = 0;
    move_pool[1] = ENTRIES - 1;
    for (int i = 2; i < POOL_SIZE; i++) move_pool[i] = $urandom_range(0, ENTRIES - 1);
    gains[0] = '1;
    gains[1] = GAIN_W'($urandom);
    gains[2] = '0;
    gains[3] = GAIN_W'($urandom);
    gains[4] = GAIN_W'($urandom);
    for (int p = 0; p < PHASES; p++) begin
      set_gain(gains[p]);
      gaps_on = (p != 2);
      repeat (PHASE_ITEMS) random_item();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_empty_table();
    test_load_query();
    test_visit_updates();
    test_select_ties();
    test_gain_extremes();
    test_clear();
    test_random();
    drain();
    repeat (50) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("puct_branch_stats_select_core_test: done, clean");
    end else begin
      $display("puct_branch_stats_select_core_test: done, errors");
    end
    $finish;
  end

endmodule

>>> puct_branch_stats_select_core.f
hdl/puct_pkg.sv
hdl/puct_ram.sv
hdl/puct_div.sv
hdl/puct_isqrt.sv
hdl/puct_branch_stats_select_core.sv
dv/puct_branch_stats_select_core_test.sv
